@@ design/fqcs_pkg.sv @@
// Package for the fair-queue CoDel scheduler: sizes, field widths, codes,
// and the command and status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package fqcs_pkg;

    // Scheduler dimensions
    localparam int NUM_BINS    = 16;
    localparam int BIN_DEPTH   = 16;
    localparam int BIN_W       = $clog2(NUM_BINS);
    localparam int SLOT_W      = $clog2(BIN_DEPTH);
    localparam int FILL_W      = $clog2(BIN_DEPTH + 1);
    localparam int RFILL_W     = $clog2(NUM_BINS + 1);
    localparam int STORE_DEPTH = NUM_BINS * BIN_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field widths
    localparam int FLOW_W   = 4;
    localparam int LEN_W    = 16;
    localparam int TIME_W   = 32;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 2;
    localparam int DROPS_W  = 8;
    localparam int QUANT_W  = 16;
    localparam int DESC_W   = LEN_W + TIME_W + TAG_W;
    localparam int CREDIT_W = 18;
    localparam int COUNT_W  = 16;

    // Control law unit
    localparam int ROOT_W    = 24;
    localparam int SQ_IN_W   = 48;
    localparam int SQ_STEPS  = 24;
    localparam int DIV_STEPS = 48;
    localparam int STEP_W    = 6;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int REG_W   = 2;
    localparam logic [REG_W-1:0] REG_TARGET   = 2'd0;
    localparam logic [REG_W-1:0] REG_INTERVAL = 2'd1;
    localparam logic [REG_W-1:0] REG_QUANTUM  = 2'd2;

    // Opcodes and result status codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;
    localparam logic [STATUS_W-1:0] ST_SENT = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ENQ  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic                accept;
        logic                enq_write;
        logic                load_front;
        logic                retire;
        logic                rotate;
        logic                pop_rd;
        logic                pop_commit;
        logic                clr_drop;
        logic                set_drop;
        logic                drops_inc;
        logic                count_inc;
        logic                count_enter;
        logic                law_start;
        logic                set_next_drop;
        logic                base_now;
        logic                credit_sub;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic opcode;
        logic ring_empty;
        logic bin_empty;
        logic bin_neg;
        logic bin_full;
        logic dropping;
        logic due;
        logic pop_valid;
        logic pop_ok;
        logic law_done;
        logic out_free;
    } t_stat;

    // Reduce the classifier bin to the bin range
    function automatic logic [BIN_W-1:0] bin_of(input logic [FLOW_W-1:0] flow);
        return BIN_W'(32'(flow) % NUM_BINS);
    endfunction

endpackage

`default_nettype wire

@@ design/fqcs_if.sv @@
// Request and response channel interfaces of the fair-queue CoDel scheduler.
// Depends on fqcs_pkg.
`default_nettype none

interface fqcs_req_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [fqcs_pkg::FLOW_W-1:0]   flow_bin;
    logic [fqcs_pkg::LEN_W-1:0]    pkt_len;
    logic [fqcs_pkg::TIME_W-1:0]   time_stamp;
    logic [fqcs_pkg::TAG_W-1:0]    pkt_tag;

    modport source (output valid, opcode, flow_bin, pkt_len, time_stamp, pkt_tag,
                    input ready);
    modport sink   (input valid, opcode, flow_bin, pkt_len, time_stamp, pkt_tag,
                    output ready);
endinterface

interface fqcs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fqcs_pkg::STATUS_W-1:0] status;
    logic [fqcs_pkg::FLOW_W-1:0]   out_bin;
    logic [fqcs_pkg::LEN_W-1:0]    out_len;
    logic [fqcs_pkg::TIME_W-1:0]   out_stamp;
    logic [fqcs_pkg::TAG_W-1:0]    out_tag;
    logic [fqcs_pkg::DROPS_W-1:0]  drops_seen;

    modport source (output valid, status, out_bin, out_len, out_stamp, out_tag, drops_seen,
                    input ready);
    modport sink   (input valid, status, out_bin, out_len, out_stamp, out_tag, drops_seen,
                    output ready);
endinterface

`default_nettype wire

@@ design/fair_queue_codel_scheduler.sv @@
// Fair-queue CoDel scheduler top: APB register block, controller, datapath.
// Enqueue: checked in S_ENQ; result loaded in S_DONE once output is free.
// Dequeue: ring steps (retire or refill) run S_PICK_LOAD, S_PICK_EVAL; pops
// run S_POP_RD, S_POP_WR; a law update takes 24 root and 48 divide steps.
// One request at a time; the next request is taken while a result waits.
// Reset is synchronous and active low; it clears all bin and ring state.
`default_nettype none

module fair_queue_codel_scheduler (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    fqcs_req_if.sink                             i_req,
    fqcs_rsp_if.source                           o_rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fqcs_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [fqcs_pkg::PDATA_W-1:0]    pwdata,
    output logic [fqcs_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);

    logic [fqcs_pkg::TIME_W-1:0]  r_target, r_interval;
    logic [fqcs_pkg::QUANT_W-1:0] r_quantum;
    logic [fqcs_pkg::REG_W-1:0]   reg_idx;
    logic                         wr_en;

    assign reg_idx = paddr[fqcs_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= 32'd5;
            r_interval <= 32'd100;
            r_quantum  <= 16'd1500;
        end else if (wr_en) begin
            unique case (reg_idx)
                fqcs_pkg::REG_TARGET:   r_target   <= pwdata;
                fqcs_pkg::REG_INTERVAL: r_interval <= pwdata;
                fqcs_pkg::REG_QUANTUM:  r_quantum  <= pwdata[fqcs_pkg::QUANT_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (reg_idx)
            fqcs_pkg::REG_TARGET:   prdata = r_target;
            fqcs_pkg::REG_INTERVAL: prdata = r_interval;
            fqcs_pkg::REG_QUANTUM:  prdata = fqcs_pkg::PDATA_W'(r_quantum);
            default:                prdata = '0;
        endcase
    end

    fqcs_pkg::t_cmd  cmd;
    fqcs_pkg::t_stat stat;

    fqcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fqcs_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_opcode     (i_req.opcode),
        .i_flow_bin   (i_req.flow_bin),
        .i_pkt_len    (i_req.pkt_len),
        .i_time_stamp (i_req.time_stamp),
        .i_pkt_tag    (i_req.pkt_tag),
        .i_target     (r_target),
        .i_interval   (r_interval),
        .i_quantum    (r_quantum),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_status     (o_rsp.status),
        .o_out_bin    (o_rsp.out_bin),
        .o_out_len    (o_rsp.out_len),
        .o_out_stamp  (o_rsp.out_stamp),
        .o_out_tag    (o_rsp.out_tag),
        .o_drops_seen (o_rsp.drops_seen)
    );

endmodule

`default_nettype wire

@@ design/fqcs_law_unit.sv @@
// CoDel control law unit: floor(interval * 65536 / isqrt(count << 32)),
// one root bit per cycle, then one quotient bit per cycle. Depends on fqcs_pkg.
`default_nettype none

module fqcs_law_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [fqcs_pkg::COUNT_W-1:0]   i_count,
    input  wire logic [fqcs_pkg::TIME_W-1:0]    i_interval,
    output logic                                o_done,
    output logic [fqcs_pkg::TIME_W-1:0]         o_quot
);

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_SQRT = 2'd1;
    localparam logic [1:0] L_DIV  = 2'd2;
    localparam logic [1:0] L_DONE = 2'd3;

    logic [1:0]                        r_state, n_state;
    logic [fqcs_pkg::STEP_W-1:0]       r_cnt, n_cnt;
    logic [fqcs_pkg::SQ_IN_W-1:0]      r_src, n_src;
    logic [fqcs_pkg::ROOT_W+2:0]       r_srem, n_srem;
    logic [fqcs_pkg::ROOT_W-1:0]       r_root, n_root;
    logic [fqcs_pkg::SQ_IN_W-1:0]      r_dvd, n_dvd;
    logic [fqcs_pkg::ROOT_W-1:0]       r_drem, n_drem;
    logic [fqcs_pkg::TIME_W-1:0]       r_quot, n_quot;

    logic [fqcs_pkg::ROOT_W+2:0]       sq_cat, sq_trial;
    logic [fqcs_pkg::ROOT_W:0]         dv_cat, dv_div;
    logic [fqcs_pkg::ROOT_W-1:0]       divisor;

    // One square root digit: bring down two bits, try (root << 2) | 1
    assign sq_cat   = {r_srem[fqcs_pkg::ROOT_W:0], r_src[fqcs_pkg::SQ_IN_W-1 -: 2]};
    assign sq_trial = {1'b0, r_root, 2'b01};

    // One quotient bit, a zero root counts as one
    assign divisor = (r_root == '0) ? fqcs_pkg::ROOT_W'(1) : r_root;
    assign dv_cat  = {r_drem, r_dvd[fqcs_pkg::SQ_IN_W-1]};
    assign dv_div  = {1'b0, divisor};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_src   = r_src;
        n_srem  = r_srem;
        n_root  = r_root;
        n_dvd   = r_dvd;
        n_drem  = r_drem;
        n_quot  = r_quot;
        unique case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_state = L_SQRT;
                    n_cnt   = fqcs_pkg::STEP_W'(fqcs_pkg::SQ_STEPS - 1);
                    n_src   = {i_count, 32'd0};
                    n_srem  = '0;
                    n_root  = '0;
                    n_dvd   = {i_interval, 16'd0};
                end
            end
            L_SQRT: begin
                n_src = {r_src[fqcs_pkg::SQ_IN_W-3:0], 2'b00};
                if (sq_cat >= sq_trial) begin
                    n_srem = sq_cat - sq_trial;
                    n_root = {r_root[fqcs_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    n_srem = sq_cat;
                    n_root = {r_root[fqcs_pkg::ROOT_W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    n_state = L_DIV;
                    n_cnt   = fqcs_pkg::STEP_W'(fqcs_pkg::DIV_STEPS - 1);
                    n_drem  = '0;
                    n_quot  = '0;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            L_DIV: begin
                n_dvd = {r_dvd[fqcs_pkg::SQ_IN_W-2:0], 1'b0};
                if (dv_cat >= dv_div) begin
                    n_drem = fqcs_pkg::ROOT_W'(dv_cat - dv_div);
                    n_quot = {r_quot[fqcs_pkg::TIME_W-2:0], 1'b1};
                end else begin
                    n_drem = fqcs_pkg::ROOT_W'(dv_cat);
                    n_quot = {r_quot[fqcs_pkg::TIME_W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    n_state = L_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            L_DONE: begin
                n_state = L_IDLE;
            end
            default: begin
                n_state = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_src  <= n_src;
        r_srem <= n_srem;
        r_root <= n_root;
        r_dvd  <= n_dvd;
        r_drem <= n_drem;
        r_quot <= n_quot;
    end

    assign o_done = (r_state == L_DONE);
    assign o_quot = r_quot;

endmodule

`default_nettype wire

@@ design/fqcs_datapath.sv @@
// Datapath of the fair-queue CoDel scheduler: per-bin FIFO and CoDel state,
// active ring, descriptor memory, control law unit and result register.
// Depends on fqcs_pkg and fqcs_law_unit.
`default_nettype none

module fqcs_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire fqcs_pkg::t_cmd                  i_cmd,
    output fqcs_pkg::t_stat                      o_stat,
    // request payload
    input  wire logic                            i_opcode,
    input  wire logic [fqcs_pkg::FLOW_W-1:0]     i_flow_bin,
    input  wire logic [fqcs_pkg::LEN_W-1:0]      i_pkt_len,
    input  wire logic [fqcs_pkg::TIME_W-1:0]     i_time_stamp,
    input  wire logic [fqcs_pkg::TAG_W-1:0]      i_pkt_tag,
    // configuration
    input  wire logic [fqcs_pkg::TIME_W-1:0]     i_target,
    input  wire logic [fqcs_pkg::TIME_W-1:0]     i_interval,
    input  wire logic [fqcs_pkg::QUANT_W-1:0]    i_quantum,
    // result
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic [fqcs_pkg::STATUS_W-1:0]        o_status,
    output logic [fqcs_pkg::FLOW_W-1:0]          o_out_bin,
    output logic [fqcs_pkg::LEN_W-1:0]           o_out_len,
    output logic [fqcs_pkg::TIME_W-1:0]          o_out_stamp,
    output logic [fqcs_pkg::TAG_W-1:0]           o_out_tag,
    output logic [fqcs_pkg::DROPS_W-1:0]         o_drops_seen
);

    localparam int NB = fqcs_pkg::NUM_BINS;
    localparam int BW = fqcs_pkg::BIN_W;
    localparam int SW = fqcs_pkg::SLOT_W;
    localparam int FW = fqcs_pkg::FILL_W;
    localparam int RW = fqcs_pkg::RFILL_W;
    localparam int AW = fqcs_pkg::ADDR_W;
    localparam int TW = fqcs_pkg::TIME_W;
    localparam int CW = fqcs_pkg::CREDIT_W;
    localparam int KW = fqcs_pkg::COUNT_W;

    // Per-bin state
    logic [SW-1:0] r_head        [NB];
    logic [FW-1:0] r_fill        [NB];
    logic [CW-1:0] r_credit      [NB];
    logic          r_active      [NB];
    logic [TW-1:0] r_first_above [NB];
    logic [TW-1:0] r_next_drop   [NB];
    logic [KW-1:0] r_count       [NB];
    logic          r_dropping    [NB];

    // Active ring
    logic [BW-1:0] r_ring [NB];
    logic [BW-1:0] r_ring_head;
    logic [RW-1:0] r_ring_fill;
    logic [TW-1:0] r_total;

    // Descriptor memory
    logic [fqcs_pkg::DESC_W-1:0] r_store [fqcs_pkg::STORE_DEPTH];
    logic [fqcs_pkg::DESC_W-1:0] r_rd_data;

    // Request and working registers
    logic                           r_opcode;
    logic [BW-1:0]                  r_bin;
    logic [fqcs_pkg::LEN_W-1:0]     r_in_len;
    logic [TW-1:0]                  r_now;
    logic [fqcs_pkg::TAG_W-1:0]     r_in_tag;
    logic [fqcs_pkg::DROPS_W-1:0]   r_drops;
    logic                           r_pop_valid;
    logic                           r_pop_ok;
    logic [fqcs_pkg::LEN_W-1:0]     r_pop_len;
    logic [TW-1:0]                  r_pop_stamp;
    logic [fqcs_pkg::TAG_W-1:0]     r_pop_tag;

    // Result register
    logic                           r_out_valid;
    logic [fqcs_pkg::STATUS_W-1:0]  r_status;
    logic [fqcs_pkg::FLOW_W-1:0]    r_out_bin;
    logic [fqcs_pkg::LEN_W-1:0]     r_out_len;
    logic [TW-1:0]                  r_out_stamp;
    logic [fqcs_pkg::TAG_W-1:0]     r_out_tag;
    logic [fqcs_pkg::DROPS_W-1:0]   r_out_drops;

    // Selected bin view
    logic [SW-1:0]  head_b;
    logic [FW-1:0]  fill_b;
    logic [CW-1:0]  credit_b;
    logic [TW-1:0]  fa_b, nd_b;
    logic [KW-1:0]  cnt_b;
    logic [fqcs_pkg::QUANT_W-1:0] qeff;

    assign head_b   = r_head[r_bin];
    assign fill_b   = r_fill[r_bin];
    assign credit_b = r_credit[r_bin];
    assign fa_b     = r_first_above[r_bin];
    assign nd_b     = r_next_drop[r_bin];
    assign cnt_b    = r_count[r_bin];
    assign qeff     = (i_quantum == '0) ? fqcs_pkg::QUANT_W'(1) : i_quantum;

    // Ring tail index and head advance
    logic [BW:0]   ring_sum;
    logic [BW-1:0] ring_tail, ring_head_nx;
    assign ring_sum     = (BW+1)'(r_ring_head) + (BW+1)'(r_ring_fill);
    assign ring_tail    = (ring_sum >= (BW+1)'(NB)) ? BW'(ring_sum - (BW+1)'(NB))
                                                    : BW'(ring_sum);
    assign ring_head_nx = (r_ring_head == BW'(NB - 1)) ? '0 : r_ring_head + 1'b1;

    // FIFO slot addresses
    logic [SW:0]   slot_sum;
    logic [SW-1:0] tail_slot, head_nx;
    logic [AW-1:0] bin_base, wr_addr, rd_addr;
    assign slot_sum  = (SW+1)'(head_b) + (SW+1)'(fill_b);
    assign tail_slot = (slot_sum >= (SW+1)'(fqcs_pkg::BIN_DEPTH))
                       ? SW'(slot_sum - (SW+1)'(fqcs_pkg::BIN_DEPTH)) : SW'(slot_sum);
    assign head_nx   = (head_b == SW'(fqcs_pkg::BIN_DEPTH - 1)) ? '0 : head_b + 1'b1;
    assign bin_base  = AW'(r_bin) * AW'(fqcs_pkg::BIN_DEPTH);
    assign wr_addr   = bin_base + AW'(tail_slot);
    assign rd_addr   = bin_base + AW'(head_b);

    logic bin_empty, bin_full;
    assign bin_empty = (fill_b == '0);
    assign bin_full  = (fill_b == FW'(fqcs_pkg::BIN_DEPTH));

    // Head descriptor and CoDel sojourn check
    logic [fqcs_pkg::LEN_W-1:0] d_len;
    logic [TW-1:0]              d_stamp, total_new, sojourn;
    logic [fqcs_pkg::TAG_W-1:0] d_tag;
    logic [FW-1:0]              fill_new;
    logic                       below;
    assign d_len     = r_rd_data[fqcs_pkg::DESC_W-1 -: fqcs_pkg::LEN_W];
    assign d_stamp   = r_rd_data[fqcs_pkg::TAG_W +: TW];
    assign d_tag     = r_rd_data[fqcs_pkg::TAG_W-1:0];
    assign total_new = r_total - TW'(d_len);
    assign fill_new  = fill_b - 1'b1;
    assign sojourn   = r_now - d_stamp;
    assign below     = (sojourn < i_target) || (total_new < TW'(qeff)) || (fill_new == '0);

    // Drop series count when a dropping state begins
    logic [TW-1:0] since_drop;
    logic          recent;
    logic [KW-1:0] cnt_enter;
    assign since_drop = r_now - nd_b;
    assign recent     = {3'b000, since_drop} < {i_interval, 3'b000};
    assign cnt_enter  = ((cnt_b > KW'(2)) && recent) ? cnt_b - KW'(2) : KW'(1);

    // Control law
    logic          law_done;
    logic [TW-1:0] law_quot, law_base;

    fqcs_law_unit u_law (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.law_start),
        .i_count    (cnt_b),
        .i_interval (i_interval),
        .o_done     (law_done),
        .o_quot     (law_quot)
    );

    assign law_base = i_cmd.base_now ? r_now : nd_b;

    // Per-bin state and ring bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NB; i++) begin
                r_head[i]        <= '0;
                r_fill[i]        <= '0;
                r_credit[i]      <= '0;
                r_active[i]      <= 1'b0;
                r_first_above[i] <= '0;
                r_next_drop[i]   <= '0;
                r_count[i]       <= '0;
                r_dropping[i]    <= 1'b0;
            end
            r_ring_head <= '0;
            r_ring_fill <= '0;
            r_total     <= '0;
        end else begin
            if (i_cmd.enq_write) begin
                r_fill[r_bin] <= fill_b + 1'b1;
                r_total       <= r_total + TW'(r_in_len);
                if (!r_active[r_bin]) begin
                    r_active[r_bin] <= 1'b1;
                    r_credit[r_bin] <= '0;
                    if (r_ring_fill < RW'(NB)) begin
                        r_ring_fill <= r_ring_fill + 1'b1;
                    end
                end
            end
            if (i_cmd.retire) begin
                r_credit[r_bin] <= '0;
                r_active[r_bin] <= 1'b0;
                if (r_ring_fill != '0) begin
                    r_ring_head <= ring_head_nx;
                    r_ring_fill <= r_ring_fill - 1'b1;
                end
            end
            if (i_cmd.rotate) begin
                r_ring_head     <= ring_head_nx;
                r_credit[r_bin] <= credit_b + CW'(qeff);
            end
            if (i_cmd.credit_sub) begin
                r_credit[r_bin] <= credit_b - CW'(r_pop_len);
            end
            if (i_cmd.pop_commit) begin
                if (bin_empty) begin
                    r_first_above[r_bin] <= '0;
                end else begin
                    r_head[r_bin] <= head_nx;
                    r_fill[r_bin] <= fill_new;
                    r_total       <= total_new;
                    if (below) begin
                        r_first_above[r_bin] <= '0;
                    end else if (fa_b == '0) begin
                        r_first_above[r_bin] <= r_now + i_interval;
                    end
                end
            end
            if (i_cmd.clr_drop) begin
                r_dropping[r_bin] <= 1'b0;
            end
            if (i_cmd.set_drop) begin
                r_dropping[r_bin] <= 1'b1;
            end
            if (i_cmd.count_inc && (cnt_b != '1)) begin
                r_count[r_bin] <= cnt_b + 1'b1;
            end
            if (i_cmd.count_enter) begin
                r_count[r_bin] <= cnt_enter;
            end
            if (i_cmd.set_next_drop) begin
                r_next_drop[r_bin] <= law_base + law_quot;
            end
        end
    end

    // Ring entries: written on bin activation and on rotation
    always_ff @(posedge i_clk) begin
        if ((i_cmd.enq_write && !r_active[r_bin] && (r_ring_fill < RW'(NB)))
            || i_cmd.rotate) begin
            r_ring[ring_tail] <= r_bin;
        end
    end

    // Descriptor memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.enq_write) begin
            r_store[wr_addr] <= {r_in_len, r_now, r_in_tag};
        end
        if (i_cmd.pop_rd) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    // Request capture, bin selection and pop result
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_opcode <= i_opcode;
            r_bin    <= fqcs_pkg::bin_of(i_flow_bin);
            r_in_len <= i_pkt_len;
            r_now    <= i_time_stamp;
            r_in_tag <= i_pkt_tag;
        end
        if (i_cmd.load_front) begin
            r_bin <= r_ring[r_ring_head];
        end
        if (i_cmd.pop_commit) begin
            r_pop_valid <= !bin_empty;
            r_pop_ok    <= !bin_empty && !below && (fa_b != '0) && (r_now >= fa_b);
            r_pop_len   <= d_len;
            r_pop_stamp <= d_stamp;
            r_pop_tag   <= d_tag;
        end
    end

    // Saturating drop counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drops <= '0;
        end else if (i_cmd.accept) begin
            r_drops <= '0;
        end else if (i_cmd.drops_inc && (r_drops != '1)) begin
            r_drops <= r_drops + 1'b1;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status    <= i_cmd.out_status;
            r_out_drops <= r_drops;
            if (i_cmd.out_status == fqcs_pkg::ST_SENT) begin
                r_out_bin   <= fqcs_pkg::FLOW_W'(r_bin);
                r_out_len   <= r_pop_len;
                r_out_stamp <= r_pop_stamp;
                r_out_tag   <= r_pop_tag;
            end else begin
                r_out_bin   <= '0;
                r_out_len   <= '0;
                r_out_stamp <= '0;
                r_out_tag   <= '0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_out_bin    = r_out_bin;
    assign o_out_len    = r_out_len;
    assign o_out_stamp  = r_out_stamp;
    assign o_out_tag    = r_out_tag;
    assign o_drops_seen = r_out_drops;

    // Status to the controller
    always_comb begin
        o_stat.opcode     = r_opcode;
        o_stat.ring_empty = (r_ring_fill == '0);
        o_stat.bin_empty  = bin_empty;
        o_stat.bin_neg    = credit_b[CW-1];
        o_stat.bin_full   = bin_full;
        o_stat.dropping   = r_dropping[r_bin];
        o_stat.due        = (r_now >= nd_b);
        o_stat.pop_valid  = r_pop_valid;
        o_stat.pop_ok     = r_pop_ok;
        o_stat.law_done   = law_done;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

endmodule

`default_nettype wire

@@ design/fqcs_ctrl.sv @@
// Controller of the fair-queue CoDel scheduler: sequences enqueue, DRR bin
// selection, CoDel pops and drops, and control law updates. Depends on fqcs_pkg.
`default_nettype none

module fqcs_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire fqcs_pkg::t_stat  i_stat,
    output fqcs_pkg::t_cmd        o_cmd
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_ENQ        = 4'd1;
    localparam logic [3:0] S_PICK_LOAD  = 4'd2;
    localparam logic [3:0] S_PICK_EVAL  = 4'd3;
    localparam logic [3:0] S_POP_RD     = 4'd4;
    localparam logic [3:0] S_POP_WR     = 4'd5;
    localparam logic [3:0] S_SERVE      = 4'd6;
    localparam logic [3:0] S_LOOP_CHK   = 4'd7;
    localparam logic [3:0] S_LOOP_POST  = 4'd8;
    localparam logic [3:0] S_ENTER_POST = 4'd9;
    localparam logic [3:0] S_LAW_START  = 4'd10;
    localparam logic [3:0] S_LAW_WAIT   = 4'd11;
    localparam logic [3:0] S_RESULT     = 4'd12;
    localparam logic [3:0] S_DONE       = 4'd13;

    // Which pop of a dequeue is in flight
    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_LOOP  = 2'd1;
    localparam logic [1:0] PH_ENTER = 2'd2;

    logic [3:0]                    r_state, n_state;
    logic [1:0]                    r_phase, n_phase;
    logic [fqcs_pkg::STATUS_W-1:0] r_status, n_status;

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.out_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_ENQ;
                end
            end
            S_ENQ: begin
                // opcode is now registered
                if (i_stat.opcode == fqcs_pkg::OP_DEQ) begin
                    n_state = S_PICK_LOAD;
                end else if (i_stat.bin_full) begin
                    n_status = fqcs_pkg::ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.enq_write = 1'b1;
                    n_status        = fqcs_pkg::ST_ENQ;
                    n_state         = S_DONE;
                end
            end
            S_PICK_LOAD: begin
                if (i_stat.ring_empty) begin
                    n_status = fqcs_pkg::ST_NONE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.load_front = 1'b1;
                    n_state          = S_PICK_EVAL;
                end
            end
            S_PICK_EVAL: begin
                priority if (i_stat.bin_empty) begin
                    o_cmd.retire = 1'b1;
                    n_state      = S_PICK_LOAD;
                end else if (i_stat.bin_neg) begin
                    o_cmd.rotate = 1'b1;
                    n_state      = S_PICK_LOAD;
                end else begin
                    n_phase = PH_FIRST;
                    n_state = S_POP_RD;
                end
            end
            S_POP_RD: begin
                o_cmd.pop_rd = 1'b1;
                n_state      = S_POP_WR;
            end
            S_POP_WR: begin
                o_cmd.pop_commit = 1'b1;
                unique case (r_phase)
                    PH_FIRST: n_state = S_SERVE;
                    PH_LOOP:  n_state = S_LOOP_POST;
                    default:  n_state = S_ENTER_POST;
                endcase
            end
            S_SERVE: begin
                priority if (i_stat.dropping) begin
                    o_cmd.clr_drop = !i_stat.pop_ok;
                    n_state        = S_LOOP_CHK;
                end else if (i_stat.pop_ok) begin
                    o_cmd.drops_inc = 1'b1;
                    n_phase         = PH_ENTER;
                    n_state         = S_POP_RD;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_LOOP_CHK: begin
                if (i_stat.due && i_stat.dropping) begin
                    o_cmd.drops_inc = 1'b1;
                    n_phase         = PH_LOOP;
                    n_state         = S_POP_RD;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_LOOP_POST: begin
                o_cmd.retire = !i_stat.pop_valid;
                if (!i_stat.pop_ok) begin
                    o_cmd.clr_drop = 1'b1;
                    n_state        = S_LOOP_CHK;
                end else begin
                    o_cmd.count_inc = 1'b1;
                    n_state         = S_LAW_START;
                end
            end
            S_ENTER_POST: begin
                o_cmd.retire      = !i_stat.pop_valid;
                o_cmd.set_drop    = 1'b1;
                o_cmd.count_enter = 1'b1;
                n_state           = S_LAW_START;
            end
            S_LAW_START: begin
                o_cmd.law_start = 1'b1;
                n_state         = S_LAW_WAIT;
            end
            S_LAW_WAIT: begin
                if (i_stat.law_done) begin
                    o_cmd.set_next_drop = 1'b1;
                    o_cmd.base_now      = (r_phase == PH_ENTER);
                    n_state = (r_phase == PH_LOOP) ? S_LOOP_CHK : S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_stat.pop_valid) begin
                    o_cmd.credit_sub = 1'b1;
                    n_status         = fqcs_pkg::ST_SENT;
                    n_state          = S_DONE;
                end else begin
                    n_state = S_PICK_LOAD;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_FIRST;
            r_status <= fqcs_pkg::ST_NONE;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_status <= n_status;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for fair_queue_codel_scheduler: an in-bench scheduler
// predictor checks every response. Depends on fqcs_pkg, fqcs_if and the top.
`default_nettype none

module tb_top;

    typedef struct {
        logic        op;
        logic [3:0]  bin;
        logic [15:0] len;
        logic [31:0] ts;
        logic [15:0] tag;
    } t_req;

    typedef struct {
        logic [1:0]  status;
        logic [3:0]  bin;
        logic [15:0] len;
        logic [31:0] stamp;
        logic [15:0] tag;
        logic [7:0]  drops;
    } t_rsp;

    typedef struct {
        bit          valid;
        bit          ok;
        logic [15:0] len;
        logic [31:0] stamp;
        logic [15:0] tag;
    } t_pop;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [fqcs_pkg::PADDR_W-1:0] paddr = '0;
    logic [fqcs_pkg::PDATA_W-1:0] pwdata = '0;
    logic [fqcs_pkg::PDATA_W-1:0] prdata;
    logic pready;

    fqcs_req_if req_if ();
    fqcs_rsp_if rsp_if ();

    fair_queue_codel_scheduler u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if), .o_rsp(rsp_if),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // Scheduler state mirror
    logic [31:0] cfg_target = 32'd5;
    logic [31:0] cfg_interval = 32'd100;
    logic [15:0] cfg_quantum = 16'd1500;
    logic [15:0] q_len [fqcs_pkg::NUM_BINS][fqcs_pkg::BIN_DEPTH];
    logic [31:0] q_stamp [fqcs_pkg::NUM_BINS][fqcs_pkg::BIN_DEPTH];
    logic [15:0] q_tag [fqcs_pkg::NUM_BINS][fqcs_pkg::BIN_DEPTH];
    int unsigned head_ptr [fqcs_pkg::NUM_BINS];
    int unsigned fill [fqcs_pkg::NUM_BINS];
    int          credit [fqcs_pkg::NUM_BINS];
    bit          active [fqcs_pkg::NUM_BINS];
    int unsigned ring [fqcs_pkg::NUM_BINS];
    int unsigned ring_head, ring_fill;
    logic [31:0] first_above [fqcs_pkg::NUM_BINS];
    logic [31:0] next_drop [fqcs_pkg::NUM_BINS];
    int unsigned series [fqcs_pkg::NUM_BINS];
    bit          dropping [fqcs_pkg::NUM_BINS];
    logic [31:0] backlog_bytes;

    t_req pending_reqs [$];
    t_rsp expected_rsps [$];
    int   fail_count = 0;
    bit   quiet = 1'b0;
    bit   hold_rsp = 1'b0;

    initial begin
        for (int b = 0; b < fqcs_pkg::NUM_BINS; b++) begin
            head_ptr[b] = 0; fill[b] = 0; credit[b] = 0; active[b] = 0; ring[b] = 0;
            first_above[b] = 0; next_drop[b] = 0; series[b] = 0; dropping[b] = 0;
        end
        ring_head = 0; ring_fill = 0; backlog_bytes = 0;
    end

    function automatic int unsigned quantum_eff();
        return (cfg_quantum == 0) ? 1 : cfg_quantum;
    endfunction

    function automatic void ring_push(int unsigned b);
        if (ring_fill >= fqcs_pkg::NUM_BINS) return;
        ring[(ring_head + ring_fill) % fqcs_pkg::NUM_BINS] = b;
        ring_fill++;
    endfunction

    function automatic void ring_pop();
        if (ring_fill == 0) return;
        ring_head = (ring_head + 1) % fqcs_pkg::NUM_BINS;
        ring_fill--;
    endfunction

    function automatic void retire_bin(int unsigned b);
        credit[b] = 0;
        ring_pop();
        active[b] = 0;
    endfunction

    // Deficit round robin selection; -1 when nothing is backlogged
    function automatic int pick_bin();
        int unsigned f;
        while (ring_fill > 0) begin
            f = ring[ring_head];
            if (fill[f] == 0) begin
                retire_bin(f);
            end else if (credit[f] < 0) begin
                ring_pop();
                ring_push(f);
                credit[f] += int'(quantum_eff());
            end else begin
                return int'(f);
            end
        end
        return -1;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Next drop time: t + interval * 65536 / sqrt(count << 32)
    function automatic logic [31:0] drop_spacing(logic [31:0] t, int unsigned count);
        longint unsigned root, q;
        root = int_sqrt(longint'(count) << 32);
        if (root == 0) root = 1;
        q = (longint'(cfg_interval) << 16) / root;
        return t + q[31:0];
    endfunction

    function automatic t_pop codel_dequeue(int unsigned b, logic [31:0] now);
        t_pop r;
        logic [31:0] sojourn;
        r = '{default: 0};
        if (fill[b] == 0) begin
            first_above[b] = 0;
            return r;
        end
        r.valid = 1;
        r.len = q_len[b][head_ptr[b]];
        r.stamp = q_stamp[b][head_ptr[b]];
        r.tag = q_tag[b][head_ptr[b]];
        head_ptr[b] = (head_ptr[b] + 1) % fqcs_pkg::BIN_DEPTH;
        fill[b]--;
        backlog_bytes -= 32'(r.len);
        sojourn = now - r.stamp;
        if (sojourn < cfg_target || backlog_bytes < quantum_eff() || fill[b] == 0)
            first_above[b] = 0;
        else if (first_above[b] == 0)
            first_above[b] = now + cfg_interval;
        else if (now >= first_above[b])
            r.ok = 1;
        return r;
    endfunction

    function automatic t_pop codel_service(int unsigned b, logic [31:0] now,
                                           inout int unsigned drops);
        t_pop r;
        logic [31:0] gap;
        r = codel_dequeue(b, now);
        if (dropping[b]) begin
            if (!r.ok) dropping[b] = 0;
            while (now >= next_drop[b] && dropping[b]) begin
                drops++;
                r = codel_dequeue(b, now);
                if (!r.valid) begin
                    first_above[b] = 0;
                    retire_bin(b);
                end
                if (!r.ok) begin
                    dropping[b] = 0;
                end else begin
                    if (series[b] < 16'hFFFF) series[b]++;
                    next_drop[b] = drop_spacing(next_drop[b], series[b]);
                end
            end
        end else if (r.ok) begin
            drops++;
            r = codel_dequeue(b, now);
            dropping[b] = 1;
            if (!r.valid) begin
                first_above[b] = 0;
                retire_bin(b);
            end
            gap = now - next_drop[b];
            if (series[b] > 2 && longint'(gap) < 8 * longint'(cfg_interval))
                series[b] = series[b] - 2;
            else
                series[b] = 1;
            next_drop[b] = drop_spacing(now, series[b]);
        end
        return r;
    endfunction

    // Expected response for one accepted request
    function automatic t_rsp schedule_request(t_req rq);
        t_rsp o;
        int unsigned b, slot, drops;
        int pb;
        t_pop r;
        o = '{default: 0};
        b = rq.bin % fqcs_pkg::NUM_BINS;
        drops = 0;
        if (rq.op == fqcs_pkg::OP_ENQ) begin
            if (fill[b] >= fqcs_pkg::BIN_DEPTH) begin
                o.status = fqcs_pkg::ST_FULL;
                return o;
            end
            slot = (head_ptr[b] + fill[b]) % fqcs_pkg::BIN_DEPTH;
            q_len[b][slot] = rq.len;
            q_stamp[b][slot] = rq.ts;
            q_tag[b][slot] = rq.tag;
            fill[b]++;
            backlog_bytes += 32'(rq.len);
            if (!active[b]) begin
                active[b] = 1;
                ring_push(b);
                credit[b] = 0;
            end
            o.status = fqcs_pkg::ST_ENQ;
            return o;
        end
        forever begin
            pb = pick_bin();
            if (pb < 0) begin
                o.status = fqcs_pkg::ST_NONE;
                o.drops = (drops > 255) ? 8'd255 : 8'(drops);
                return o;
            end
            r = codel_service(pb, rq.ts, drops);
            if (r.valid) begin
                credit[pb] -= int'(r.len);
                o.status = fqcs_pkg::ST_SENT;
                o.bin = 4'(pb);
                o.len = r.len;
                o.stamp = r.stamp;
                o.tag = r.tag;
                o.drops = (drops > 255) ? 8'd255 : 8'(drops);
                return o;
            end
        end
    endfunction

    // Request driver: changes on the falling edge
    bit   req_fire = 1'b0;
    int   req_gap = 0;
    t_req next_req;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_fire) begin
            if (req_gap > 0) begin
                req_gap = req_gap - 1;
                req_if.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                req_gap = $urandom_range(0, 11);
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                next_req = pending_reqs.pop_front();
                req_if.valid      <= 1'b1;
                req_if.opcode     <= next_req.op;
                req_if.flow_bin   <= next_req.bin;
                req_if.pkt_len    <= next_req.len;
                req_if.time_stamp <= next_req.ts;
                req_if.pkt_tag    <= next_req.tag;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.opcode = fqcs_pkg::OP_ENQ;
        req_if.flow_bin = '0;
        req_if.pkt_len = '0;
        req_if.time_stamp = '0;
        req_if.pkt_tag = '0;
        rsp_if.ready = 1'b0;
    end

    // Response ready: random stall bursts, plus one long hold-off
    int rsp_stall = 0;
    always @(negedge i_clk) begin
        if (hold_rsp) begin
            rsp_stall = 400;
            hold_rsp = 1'b0;
        end
        if (rsp_stall > 0) begin
            rsp_stall = rsp_stall - 1;
            rsp_if.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 12) == 0) begin
            rsp_stall = $urandom_range(0, 11);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Monitors: predict on request accept, compare on response accept
    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h actual 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        t_req rq;
        req_fire = i_rst_n && req_if.valid && req_if.ready;
        if (req_fire) begin
            rq = '{req_if.opcode, req_if.flow_bin, req_if.pkt_len,
                   req_if.time_stamp, req_if.pkt_tag};
            expected_rsps.push_back(schedule_request(rq));
        end
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_rsps.size() == 0) begin
                $error("response with no request outstanding");
                fail_count++;
            end else begin
                want = expected_rsps.pop_front();
                check_field("status", want.status, rsp_if.status);
                check_field("out_bin", want.bin, rsp_if.out_bin);
                check_field("out_len", want.len, rsp_if.out_len);
                check_field("out_stamp", want.stamp, rsp_if.out_stamp);
                check_field("out_tag", want.tag, rsp_if.out_tag);
                check_field("drops_seen", want.drops, rsp_if.drops_seen);
            end
        end
    end

    // Stimulus helpers
    logic [31:0] now_t = 0;

    task automatic add_req(logic op, logic [3:0] bin, logic [15:0] len,
                           logic [31:0] ts, logic [15:0] tag);
        pending_reqs.push_back('{op, bin, len, ts, tag});
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [fqcs_pkg::REG_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= fqcs_pkg::PADDR_W'(idx) << 2; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            fqcs_pkg::REG_TARGET:   cfg_target = val;
            fqcs_pkg::REG_INTERVAL: cfg_interval = val;
            fqcs_pkg::REG_QUANTUM:  cfg_quantum = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_config(logic [31:0] tgt, logic [31:0] ivl, logic [15:0] qb);
        reg_write(fqcs_pkg::REG_TARGET, tgt);
        reg_write(fqcs_pkg::REG_INTERVAL, ivl);
        reg_write(fqcs_pkg::REG_QUANTUM, {16'd0, qb});
    endtask

    // Mix of enqueues and dequeues on a moving clock; few hot bins build backlog
    task automatic random_phase(int n, int max_step);
        logic [15:0] len;
        logic [3:0]  bin;
        for (int i = 0; i < n; i++) begin
            now_t += $urandom_range(0, max_step);
            if ($urandom_range(0, 49) == 0) now_t = $urandom;
            case ($urandom_range(0, 9))
                0:       len = 16'($urandom);
                1:       len = ($urandom_range(0, 1)) ? 16'd0 : 16'hFFFF;
                default: len = 16'($urandom_range(40, 1500));
            endcase
            bin = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < 52)
                add_req(fqcs_pkg::OP_ENQ, bin, len, now_t - $urandom_range(0, 3),
                        16'($urandom));
            else
                add_req(fqcs_pkg::OP_DEQ, 4'($urandom), 16'($urandom), now_t,
                        16'($urandom));
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty dequeue, field extremes, full bin, drain
        add_req(fqcs_pkg::OP_DEQ, 4'd0, 16'd0, 32'd0, 16'd0);
        add_req(fqcs_pkg::OP_ENQ, 4'd0, 16'd0, 32'd0, 16'd0);
        add_req(fqcs_pkg::OP_ENQ, 4'hF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        for (int i = 0; i < 17; i++)
            add_req(fqcs_pkg::OP_ENQ, 4'd5, 16'(100 + i), 32'(i), 16'(16'hA5A5 ^ i));
        for (int i = 0; i < 5; i++)
            add_req(fqcs_pkg::OP_DEQ, 4'hF, 16'hFFFF, 32'(1000 + 60 * i), 16'hFFFF);
        wait_idle();

        random_phase(380, 30);
        wait_idle();

        // Zero target, shortest interval, zero quantum
        set_config(32'd0, 32'd1, 16'd0);
        random_phase(380, 10);
        wait_idle();

        // Mid settings with a long response hold-off
        set_config(32'd20, 32'd50, 16'd200);
        hold_rsp = 1'b1;
        random_phase(380, 25);
        wait_idle();

        // Largest values
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        random_phase(380, 40);
        wait_idle();

        // Back to defaults, no idling
        set_config(32'd5, 32'd100, 16'd1500);
        quiet = 1'b1;
        random_phase(380, 30);
        wait_idle();
        repeat (200) @(posedge i_clk);

        if (fail_count == 0 && expected_rsps.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
